// ===== src/sfb_pkg.sv =====
// sfb_pkg: shared types and constants for the spi slave frame buffer
// no dependencies; imported by every module of the block

package sfb_pkg;

    // widest frame address (frames of up to 256 bytes)
    localparam int ADDR_W_MAX = 8;
    localparam int CFG_ADDR_W = 1;

    // kind of input word, carried on s_tuser
    typedef enum logic [1:0] {
        REQ_SPI_BYTE   = 2'd0,
        REQ_IDLE_CHECK = 2'd1,
        REQ_HOST_WRITE = 2'd2,
        REQ_HOST_READ  = 2'd3
    } req_type_t;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_USE_FRAME_SYNC  = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_USE_EXT_SELECT  = 1'b1;

    // one input word after unpacking
    typedef struct packed {
        req_type_t   req_type;
        logic [7:0]  rx_byte;
        logic        sync_level;
        logic        select_level;
        logic [4:0]  host_index;
        logic [7:0]  host_data;
        logic        host_last;
    } sfb_item_t;

    // memory commands from the control unit; the enables are qualified by the advance strobe, read_valid is not
    typedef struct packed {
        logic                  rx_we;
        logic [ADDR_W_MAX-1:0] rx_waddr;
        logic                  rx_re;
        logic [ADDR_W_MAX-1:0] rx_raddr;
        logic                  tx_we;
        logic [ADDR_W_MAX-1:0] tx_waddr;
        logic                  tx_re;
        logic [ADDR_W_MAX-1:0] tx_raddr;
        logic                  read_valid;
    } sfb_cmd_t;

endpackage

// ===== src/sfb_frame_ram.sv =====
// sfb_frame_ram: one frame store, one write and one registered read port
// uses sfb_pkg; never-written entries read as zero through per-entry valid bits

module sfb_frame_ram #(
    parameter int DEPTH = 32
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       wr_en,
    input  logic [$clog2(DEPTH)-1:0]   wr_addr,
    input  logic [7:0]                 wr_data,
    input  logic                       rd_en,
    input  logic [$clog2(DEPTH)-1:0]   rd_addr,
    output logic [7:0]                 rd_data
);
    import sfb_pkg::*;

    logic [7:0]       mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [7:0]       rd_data_reg;
    logic             rd_ok_reg;
    logic             same_addr;

    assign same_addr = wr_en && (wr_addr == rd_addr);

    // storage write and registered read, new data forwarded on a same-address hit
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= same_addr ? wr_data : mem[rd_addr];
        end
    end

    // entry valid bits and read qualifier
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            rd_ok_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_ok_reg <= same_addr || valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_ok_reg ? rd_data_reg : 8'h00;

endmodule

// ===== src/sfb_ctrl.sv =====
// sfb_ctrl: frame positions, sync tracking, ready flag and configuration registers
// uses sfb_pkg; drives the memory commands for the word in the input register

module sfb_ctrl #(
    parameter int FRAME_BYTES = 32
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [sfb_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic                            cfg_wdata,
    input  logic                            advance,
    input  sfb_pkg::sfb_item_t              item,
    output sfb_pkg::sfb_cmd_t               cmd,
    output logic                            frame_ready
);
    import sfb_pkg::*;

    localparam int AW = $clog2(FRAME_BYTES);
    localparam logic [AW:0] FRAME_LEN = (AW + 1)'(FRAME_BYTES);
    localparam logic [8:0]  FRAME_LEN_W = 9'(FRAME_BYTES);

    logic          use_fs_reg;
    logic          use_sel_reg;
    logic [AW-1:0] rx_pos_reg, rx_pos_next;
    logic [AW-1:0] tx_pos_reg, tx_pos_next;
    logic          ready_reg, ready_next;
    logic          sync_seen_reg, sync_seen_next;

    logic [AW-1:0] rp_base, tp_base, tp_new;
    logic [AW:0]   rp_inc, tp_inc;
    logic          rx_wrap, tx_wrap;
    logic [8:0]    hidx_ext;
    logic          in_range;
    logic          rewind;
    logic          load_shift;
    logic [AW-1:0] shift_addr;
    logic          rx_we, rx_re, tx_we, rd_valid;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            use_fs_reg  <= 1'b0;
            use_sel_reg <= 1'b1;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_USE_FRAME_SYNC: use_fs_reg  <= cfg_wdata;
                CFG_USE_EXT_SELECT: use_sel_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // positions for a received byte; with frame sync in use, the first byte after sync starts a new frame
    assign rp_base = (use_fs_reg && !sync_seen_reg) ? '0 : rx_pos_reg;
    assign tp_base = (use_fs_reg && !sync_seen_reg) ? '0 : tx_pos_reg;
    assign rp_inc  = {1'b0, rp_base} + 1'b1;
    assign tp_inc  = {1'b0, tp_base} + 1'b1;
    assign rx_wrap = (rp_inc == FRAME_LEN);
    assign tx_wrap = (tp_inc == FRAME_LEN);
    assign tp_new  = tx_wrap ? '0 : tp_inc[AW-1:0];

    // host offset check
    assign hidx_ext = {4'b0000, item.host_index};
    assign in_range = (hidx_ext < FRAME_LEN_W);

    // next state and memory requests
    always_comb begin
        rx_pos_next    = rx_pos_reg;
        tx_pos_next    = tx_pos_reg;
        ready_next     = ready_reg;
        sync_seen_next = sync_seen_reg;
        rewind         = 1'b0;
        load_shift     = 1'b0;
        shift_addr     = '0;
        rx_we          = 1'b0;
        rx_re          = 1'b0;
        tx_we          = 1'b0;
        rd_valid       = 1'b0;
        case (item.req_type)
            REQ_SPI_BYTE: begin
                if (use_fs_reg && item.sync_level) begin
                    rewind = 1'b1;
                end else begin
                    sync_seen_next = sync_seen_reg || use_fs_reg;
                    rx_we          = 1'b1;
                    rx_pos_next    = rx_wrap ? '0 : rp_inc[AW-1:0];
                    ready_next     = ready_reg || rx_wrap;
                    tx_pos_next    = tp_new;
                    load_shift     = 1'b1;
                    shift_addr     = tp_new;
                end
            end
            REQ_IDLE_CHECK: begin
                rewind = (use_fs_reg && item.sync_level) ||
                         (use_sel_reg && item.select_level);
            end
            REQ_HOST_WRITE: begin
                tx_we = in_range;
                if (item.host_last) begin
                    tx_pos_next = '0;
                    load_shift  = 1'b1;
                end
            end
            REQ_HOST_READ: begin
                if (ready_reg) begin
                    rd_valid = 1'b1;
                    rx_re    = in_range;
                    if (item.host_last) begin
                        ready_next = 1'b0;
                    end
                end
            end
            default: ;
        endcase
        if (rewind) begin
            sync_seen_next = 1'b0;
            rx_pos_next    = '0;
            tx_pos_next    = '0;
            load_shift     = 1'b1;
        end
    end

    // command outputs
    always_comb begin
        cmd.rx_we      = advance && rx_we;
        cmd.rx_waddr   = ADDR_W_MAX'(rp_base);
        cmd.rx_re      = advance && rx_re;
        cmd.rx_raddr   = hidx_ext[ADDR_W_MAX-1:0];
        cmd.tx_we      = advance && tx_we;
        cmd.tx_waddr   = hidx_ext[ADDR_W_MAX-1:0];
        cmd.tx_re      = advance && load_shift;
        cmd.tx_raddr   = ADDR_W_MAX'(shift_addr);
        cmd.read_valid = rd_valid;
    end

    // state registers, moved once per processed word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rx_pos_reg    <= '0;
            tx_pos_reg    <= '0;
            ready_reg     <= 1'b0;
            sync_seen_reg <= 1'b0;
        end else if (advance) begin
            rx_pos_reg    <= rx_pos_next;
            tx_pos_reg    <= tx_pos_next;
            ready_reg     <= ready_next;
            sync_seen_reg <= sync_seen_next;
        end
    end

    assign frame_ready = ready_reg;

endmodule

// ===== src/spi_slave_frame_buffer.sv =====
// spi_slave_frame_buffer: top level of the fixed-length spi slave frame buffer
// uses sfb_pkg, sfb_ctrl and two sfb_frame_ram instances

// Accepts one word per clock while s_tready is high and returns exactly one result
// word for each, through the input register, then the result register with the
// frame store read data. The single pass through the control unit and one read per
// frame store sets the one-word-per-cycle rate; s_tready drops only while the result
// register is full and m_tready is low. Both frame stores read as zero after reset
// through per-entry valid bits, so there is no clearing pass. Configuration is written
// through cfg_wr_en/cfg_addr/cfg_wdata; the user must write it only while idle, the block does not enforce this.

module spi_slave_frame_buffer #(
    parameter int FRAME_BYTES = 32
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration write port
    input  logic                            cfg_wr_en,
    input  logic [sfb_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic                            cfg_wdata,
    // input words
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // rx_byte[7:0], sync_level[8], select_level[9], host_index[14:10],
    // host_data[22:15], zero[23]
    input  logic [23:0]                     s_tdata,
    // req_type[1:0]
    input  logic [1:0]                      s_tuser,
    // host_last
    input  logic                            s_tlast,
    // result words
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // miso_byte[7:0], read_byte[15:8], frame_ready[16], zero[23:17]
    output logic [23:0]                     m_tdata,
    // read_valid
    output logic                            m_tuser
);
    import sfb_pkg::*;

    localparam int AW = $clog2(FRAME_BYTES);

    logic       in_valid_reg;
    sfb_item_t  item_reg;
    logic       out_valid_reg;
    logic       advance;
    sfb_cmd_t   cmd;
    logic       frame_ready;
    logic       read_valid_reg;
    logic       rd_hit_reg;
    logic [7:0] rx_rd_data;
    logic [7:0] tx_rd_data;

    // handshake: a word moves on when the result register is free or being emptied
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            item_reg.req_type     <= req_type_t'(s_tuser);
            item_reg.rx_byte      <= s_tdata[7:0];
            item_reg.sync_level   <= s_tdata[8];
            item_reg.select_level <= s_tdata[9];
            item_reg.host_index   <= s_tdata[14:10];
            item_reg.host_data    <= s_tdata[22:15];
            item_reg.host_last    <= s_tlast;
        end
    end

    // control unit
    sfb_ctrl #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .advance     (advance),
        .item        (item_reg),
        .cmd         (cmd),
        .frame_ready (frame_ready)
    );

    // receive frame store
    sfb_frame_ram #(
        .DEPTH (FRAME_BYTES)
    ) u_rx_ram (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (cmd.rx_we),
        .wr_addr (cmd.rx_waddr[AW-1:0]),
        .wr_data (item_reg.rx_byte),
        .rd_en   (cmd.rx_re),
        .rd_addr (cmd.rx_raddr[AW-1:0]),
        .rd_data (rx_rd_data)
    );

    // transmit frame store; its held read data is the byte loaded for shift out
    sfb_frame_ram #(
        .DEPTH (FRAME_BYTES)
    ) u_tx_ram (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (cmd.tx_we),
        .wr_addr (cmd.tx_waddr[AW-1:0]),
        .wr_data (item_reg.host_data),
        .rd_en   (cmd.tx_re),
        .rd_addr (cmd.tx_raddr[AW-1:0]),
        .rd_data (tx_rd_data)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            read_valid_reg <= cmd.read_valid;
            rd_hit_reg     <= cmd.rx_re;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = read_valid_reg;
    assign m_tdata  = {7'b0000000, frame_ready, (rd_hit_reg ? rx_rd_data : 8'h00),
                       tx_rd_data};

endmodule

// ===== src/sfb_checker.sv =====
// sfb_checker: port-level checks for the spi slave frame buffer
// uses sfb_pkg; bound to spi_slave_frame_buffer at the end of this file

module sfb_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [sfb_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic                            cfg_wdata,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [23:0]                     s_tdata,
    input  logic [1:0]                      s_tuser,
    input  logic                            s_tlast,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [23:0]                     m_tdata,
    input  logic                            m_tuser
);
    import sfb_pkg::*;

    // no result word straight after reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result word visible after reset");

    // input side stalls only behind a full, stalled result register
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled without a pending result word");

    // read byte is zero unless the word carries a valid host read
    a_read_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata[15:8] == 8'h00))
        else $error("read byte set without a valid read");

    // stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result word changed");

endmodule

bind spi_slave_frame_buffer sfb_checker u_sfb_checker (.*);
